// ===== rtl/core/uart_pkg.sv =====
// Shared constants and types for the 8N1 UART with transmit and receive FIFOs.
`default_nettype none

package uart_pkg;

  localparam int unsigned FIFO_DEPTH = 16;
  localparam int unsigned FifoAw     = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned DataBits   = 8;
  localparam int unsigned FrameBits  = DataBits + 2;
  localparam int unsigned TpbW       = 16;
  localparam logic [TpbW-1:0] TpbReset = 16'd434;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_PUSH = 2'd1,
    OP_POP  = 2'd2
  } op_e;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/uart_fifo.sv =====
// Ring FIFO of FIFO_DEPTH bytes with a full flag and a head read port.
`default_nettype none

module uart_fifo
  import uart_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire logic [DataBits-1:0] wdata_i,
  input  wire logic                pop_i,
  output logic      [DataBits-1:0] rdata_o,
  output fifo_stat_t               stat_o
);

  logic [DataBits-1:0] store_q [FIFO_DEPTH];
  logic [FifoAw-1:0]   head_q, head_d;
  logic [FifoAw-1:0]   tail_q, tail_d;
  logic                full_q, full_d;
  logic                empty;
  logic                do_push;
  logic                do_pop;

  function automatic logic [FifoAw-1:0] next_ptr(input logic [FifoAw-1:0] p);
    if (p == FifoAw'(FIFO_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  assign empty   = !full_q && (head_q == tail_q);
  assign do_push = push_i && !full_q;
  assign do_pop  = pop_i && !empty;

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    full_d = full_q;
    if (do_push) begin
      tail_d = next_ptr(tail_q);
      if (tail_d == head_q) begin
        full_d = 1'b1;
      end
    end
    if (do_pop) begin
      head_d = next_ptr(head_q);
      full_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      full_q <= 1'b0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      full_q <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[tail_q] <= wdata_i;
    end
  end

  assign rdata_o      = store_q[head_q];
  assign stat_o.empty = empty;
  assign stat_o.full  = full_q;

endmodule

`default_nettype wire

// ===== rtl/core/uart_tx.sv =====
// Transmit serializer: start bit, eight data bits LSB first, stop bit.
`default_nettype none

module uart_tx
  import uart_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                tick_i,
  input  wire logic [TpbW-1:0]     ticks_per_bit_i,
  input  wire fifo_stat_t          fifo_stat_i,
  input  wire logic [DataBits-1:0] fifo_rdata_i,
  output logic                     fifo_pop_o,
  output logic                     tx_line_o
);

  logic [FrameBits-1:0] shifter_q, shifter_d;
  logic [3:0]           bits_left_q, bits_left_d;
  logic [TpbW-1:0]      count_q, count_d;
  logic [TpbW-1:0]      count_inc;

  assign count_inc = count_q + 1'b1;

  always_comb begin
    shifter_d   = shifter_q;
    bits_left_d = bits_left_q;
    count_d     = count_q;
    fifo_pop_o  = 1'b0;
    if (tick_i) begin
      if (bits_left_q != '0) begin
        if (count_inc >= ticks_per_bit_i) begin
          count_d     = '0;
          shifter_d   = {1'b1, shifter_q[FrameBits-1:1]};
          bits_left_d = bits_left_q - 1'b1;
        end else begin
          count_d = count_inc;
        end
      end
      if ((bits_left_d == '0) && !fifo_stat_i.empty) begin
        fifo_pop_o  = 1'b1;
        shifter_d   = {1'b1, fifo_rdata_i, 1'b0};
        bits_left_d = 4'(FrameBits);
        count_d     = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shifter_q   <= '1;
      bits_left_q <= '0;
      count_q     <= '0;
    end else begin
      shifter_q   <= shifter_d;
      bits_left_q <= bits_left_d;
      count_q     <= count_d;
    end
  end

  assign tx_line_o = (bits_left_q != '0) ? shifter_q[0] : 1'b1;

endmodule

`default_nettype wire

// ===== rtl/core/uart_rx.sv =====
// Receive deserializer with start detect, center sampling and drop counter.
`default_nettype none

module uart_rx
  import uart_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                tick_i,
  input  wire logic                rx_line_i,
  input  wire logic [TpbW-1:0]     ticks_per_bit_i,
  input  wire fifo_stat_t          fifo_stat_i,
  output logic                     fifo_push_o,
  output logic      [DataBits-1:0] fifo_wdata_o,
  output logic      [15:0]         dropped_o
);

  typedef enum logic [1:0] {
    IDLE,
    START,
    DATA,
    STOP
  } phase_e;

  phase_e              phase_q, phase_d;
  logic [DataBits-1:0] shifter_q, shifter_d;
  logic [2:0]          bit_idx_q, bit_idx_d;
  logic [TpbW-1:0]     count_q, count_d;
  logic [TpbW-1:0]     count_inc;
  logic                prev_q, prev_d;
  logic [15:0]         drop_q, drop_d;

  assign count_inc = count_q + 1'b1;

  always_comb begin
    phase_d     = phase_q;
    shifter_d   = shifter_q;
    bit_idx_d   = bit_idx_q;
    count_d     = count_q;
    prev_d      = prev_q;
    drop_d      = drop_q;
    fifo_push_o = 1'b0;
    if (tick_i) begin
      prev_d = rx_line_i;
      unique case (phase_q)
        IDLE: begin
          if (prev_q && !rx_line_i) begin
            phase_d = START;
            count_d = '0;
          end
        end
        START: begin
          count_d = count_inc;
          if (count_inc >= (ticks_per_bit_i >> 1)) begin
            count_d = '0;
            if (rx_line_i) begin
              phase_d = IDLE;
            end else begin
              phase_d   = DATA;
              bit_idx_d = '0;
              shifter_d = '0;
            end
          end
        end
        DATA: begin
          count_d = count_inc;
          if (count_inc >= ticks_per_bit_i) begin
            count_d              = '0;
            shifter_d[bit_idx_q] = rx_line_i;
            bit_idx_d            = bit_idx_q + 1'b1;
            if (bit_idx_q == 3'(DataBits - 1)) begin
              phase_d = STOP;
            end
          end
        end
        STOP: begin
          count_d = count_inc;
          if (count_inc >= ticks_per_bit_i) begin
            count_d = '0;
            phase_d = IDLE;
            if (fifo_stat_i.full) begin
              if (drop_q != '1) begin
                drop_d = drop_q + 1'b1;
              end
            end else begin
              fifo_push_o = 1'b1;
            end
          end
        end
        default: phase_d = IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= IDLE;
      shifter_q <= '0;
      bit_idx_q <= '0;
      count_q   <= '0;
      prev_q    <= 1'b1;
      drop_q    <= '0;
    end else begin
      phase_q   <= phase_d;
      shifter_q <= shifter_d;
      bit_idx_q <= bit_idx_d;
      count_q   <= count_d;
      prev_q    <= prev_d;
      drop_q    <= drop_d;
    end
  end

  assign fifo_wdata_o = shifter_q;
  assign dropped_o    = drop_q;

endmodule

`default_nettype wire

// ===== rtl/core/uart_8n1_with_fifos.sv =====
// Top level: 8N1 UART with transmit and receive FIFOs on a word stream.
//
//  channel   | direction | tdata (low bit up)                              | tuser
//  s_axis    | in        | write_byte[7:0], rx_line[8], zero pad to 16     | opcode[1:0]
//  m_axis    | out       | tx_line, read_byte, tx_full, rx_available,      | read_valid
//            |           | dropped_frames, zero pad to 32                  |
//  cfg       | in        | ticks_per_bit[15:0] written when cfg_we_i high  |
//
// One word per cycle sustained while m_axis_tready is high: a word is held in the input register,
// then, as it leaves that register, updates the FIFO pointers, bit counters and serializers together.
// The result word is the state after that update plus the popped byte.
// A stalled m_axis holds the result and the input register; nothing advances.
// Reset clears all pointers and counters; ticks_per_bit returns to 434.
`default_nettype none

module uart_8n1_with_fifos
  import uart_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // write_byte[7:0], rx_line[8]
  input  wire logic [1:0]  s_axis_tuser,   // opcode[1:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [31:0] m_axis_tdata,   // tx_line[0], read_byte[8:1], tx_full[9],
                                           // rx_available[10], dropped_frames[26:11]
  output logic      [0:0]  m_axis_tuser,   // read_valid[0]
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i
);

  logic [TpbW-1:0]     tpb_q;
  logic                in_valid_q;
  logic [1:0]          opcode_q;
  logic [DataBits-1:0] wbyte_q;
  logic                rxl_q;
  logic                out_valid_q;
  logic [DataBits-1:0] rbyte_q, rbyte_d;
  logic                rvalid_q, rvalid_d;
  logic                advance;
  logic                tick;
  logic                push;
  logic                pop;

  fifo_stat_t          tx_stat;
  fifo_stat_t          rx_stat;
  logic [DataBits-1:0] tx_rdata;
  logic [DataBits-1:0] rx_rdata;
  logic [DataBits-1:0] rx_wdata;
  logic                tx_pop;
  logic                rx_push;
  logic                tx_line;
  logic [15:0]         dropped;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign tick          = advance && (opcode_q == OP_TICK);
  assign push          = advance && (opcode_q == OP_PUSH);
  assign pop           = advance && (opcode_q == OP_POP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpb_q <= TpbReset;
    end else if (cfg_we_i) begin
      tpb_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      opcode_q <= s_axis_tuser;
      wbyte_q  <= s_axis_tdata[DataBits-1:0];
      rxl_q    <= s_axis_tdata[DataBits];
    end
  end

  always_comb begin
    rbyte_d  = '0;
    rvalid_d = 1'b0;
    if (pop && !rx_stat.empty) begin
      rbyte_d  = rx_rdata;
      rvalid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      rbyte_q     <= '0;
      rvalid_q    <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
      rbyte_q     <= rbyte_d;
      rvalid_q    <= rvalid_d;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  uart_fifo u_tx_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (wbyte_q),
    .pop_i   (tx_pop),
    .rdata_o (tx_rdata),
    .stat_o  (tx_stat)
  );

  uart_fifo u_rx_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rx_push),
    .wdata_i (rx_wdata),
    .pop_i   (pop),
    .rdata_o (rx_rdata),
    .stat_o  (rx_stat)
  );

  uart_tx u_tx (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .tick_i          (tick),
    .ticks_per_bit_i (tpb_q),
    .fifo_stat_i     (tx_stat),
    .fifo_rdata_i    (tx_rdata),
    .fifo_pop_o      (tx_pop),
    .tx_line_o       (tx_line)
  );

  uart_rx u_rx (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .tick_i          (tick),
    .rx_line_i       (rxl_q),
    .ticks_per_bit_i (tpb_q),
    .fifo_stat_i     (rx_stat),
    .fifo_push_o     (rx_push),
    .fifo_wdata_o    (rx_wdata),
    .dropped_o       (dropped)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, dropped, !rx_stat.empty, tx_stat.full, rbyte_q, tx_line};
  assign m_axis_tuser  = rvalid_q;

endmodule

`default_nettype wire

// ===== dv/uart_8n1_with_fifos_test.sv =====
// Self-checking stream testbench for the 8N1 UART with transmit and receive FIFOs.
module uart_8n1_with_fifos_test;
  import uart_pkg::*;

  localparam logic [1:0] OpUnused = 2'd3;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned StallLimit = 4000;

  typedef enum logic [1:0] {RX_IDLE, RX_START, RX_DATA, RX_STOP} rx_phase_e;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data;
    logic       level;
  } word_t;

  typedef struct packed {
    logic        tx_line;
    logic [7:0]  read_byte;
    logic        read_valid;
    logic        tx_full;
    logic        rx_avail;
    logic [15:0] drops;
  } status_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;

  uart_8n1_with_fifos dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #10 clk_i = ~clk_i;

  word_t       pending_words[$];
  status_t     status_due[$];
  int unsigned words_queued = 0, words_in = 0, words_out = 0, stim_count = 0;
  int unsigned errors = 0, settings_used = 0;
  int unsigned gap_pct = 0, stall_pct = 0, push_pct = 0, pop_pct = 0, odd_pct = 0;
  int unsigned hold_asks = 0, hold_done, hold_left, ready_gap, send_gap, quiet_cycles;

  logic [15:0] bit_ticks;
  logic [7:0]  tx_mem[FIFO_DEPTH];
  logic [7:0]  rx_mem[FIFO_DEPTH];
  int unsigned tx_rd, tx_wr, rx_rd, rx_wr;
  logic        tx_full_m, rx_full_m;
  logic [9:0]  tx_sh;
  int unsigned tx_left, rx_idx;
  logic [15:0] tx_cnt, rx_cnt, drops_m;
  rx_phase_e   rx_ph;
  logic [7:0]  rx_sh;
  logic        rx_last;
  int unsigned frames_kept, bytes_sent;

  function automatic int unsigned wrap_inc(int unsigned ptr);
    return (ptr == FIFO_DEPTH - 1) ? 0 : ptr + 1;
  endfunction

  function automatic logic rx_has_data();
    return rx_full_m || rx_rd != rx_wr;
  endfunction

  function automatic status_t uart_next_status(logic [1:0] op, logic [7:0] wbyte, logic level);
    status_t r;
    r = '0;
    case (op)
      OP_TICK: begin
        if (tx_left != 0) begin
          tx_cnt = tx_cnt + 16'd1;
          if (tx_cnt >= bit_ticks) begin
            tx_cnt = '0;
            tx_sh = {1'b1, tx_sh[9:1]};
            tx_left--;
          end
        end
        if (tx_left == 0 && (tx_full_m || tx_rd != tx_wr)) begin
          tx_sh = {1'b1, tx_mem[tx_rd], 1'b0};
          tx_rd = wrap_inc(tx_rd);
          tx_full_m = 1'b0;
          tx_left = FrameBits;
          tx_cnt = '0;
          bytes_sent++;
        end
        if (rx_ph == RX_IDLE) begin
          if (rx_last && !level) begin
            rx_ph = RX_START;
            rx_cnt = '0;
          end
        end else begin
          rx_cnt = rx_cnt + 16'd1;
          if (rx_ph == RX_START) begin
            if (rx_cnt >= (bit_ticks >> 1)) begin
              rx_cnt = '0;
              if (level) begin
                rx_ph = RX_IDLE;
              end else begin
                rx_ph = RX_DATA;
                rx_idx = 0;
                rx_sh = '0;
              end
            end
          end else if (rx_cnt >= bit_ticks) begin
            rx_cnt = '0;
            if (rx_ph == RX_DATA) begin
              rx_sh[rx_idx] = level;
              rx_idx++;
              if (rx_idx >= DataBits) begin
                rx_idx = 0;
                rx_ph = RX_STOP;
              end
            end else begin
              if (rx_full_m) begin
                if (drops_m != 16'hFFFF) drops_m++;
              end else begin
                rx_mem[rx_wr] = rx_sh;
                rx_wr = wrap_inc(rx_wr);
                if (rx_wr == rx_rd) rx_full_m = 1'b1;
                frames_kept++;
              end
              rx_ph = RX_IDLE;
            end
          end
        end
        rx_last = level;
      end
      OP_PUSH: begin
        if (!tx_full_m) begin
          tx_mem[tx_wr] = wbyte;
          tx_wr = wrap_inc(tx_wr);
          if (tx_wr == tx_rd) tx_full_m = 1'b1;
        end
      end
      OP_POP: begin
        if (rx_has_data()) begin
          r.read_byte = rx_mem[rx_rd];
          r.read_valid = 1'b1;
          rx_rd = wrap_inc(rx_rd);
          rx_full_m = 1'b0;
        end
      end
      default: ;
    endcase
    r.tx_line = (tx_left != 0) ? tx_sh[0] : 1'b1;
    r.tx_full = tx_full_m;
    r.rx_avail = rx_has_data();
    r.drops = drops_m;
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin : drive_words
    word_t w;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      send_gap <= 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (send_gap != 0) begin
        send_gap <= send_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pending_words.size() != 0 && $urandom_range(0, 99) < gap_pct) begin
        send_gap <= $urandom_range(0, 12);
        s_axis_tvalid <= 1'b0;
      end else if (pending_words.size() != 0) begin
        w = pending_words.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {7'd0, w.level, w.data};
        s_axis_tuser <= w.op;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      ready_gap <= 0;
      hold_left <= 0;
      hold_done <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_done != hold_asks) begin
      hold_done <= hold_asks;
      hold_left <= HoldCycles;
      m_axis_tready <= 1'b0;
    end else if (ready_gap != 0) begin
      ready_gap <= ready_gap - 1;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      ready_gap <= $urandom_range(0, 12);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : check_words
    status_t got, want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        status_due.push_back(uart_next_status(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[8]));
        words_in++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.tx_line = m_axis_tdata[0];
        got.read_byte = m_axis_tdata[8:1];
        got.read_valid = m_axis_tuser[0];
        got.tx_full = m_axis_tdata[9];
        got.rx_avail = m_axis_tdata[10];
        got.drops = m_axis_tdata[26:11];
        words_out++;
        if (status_due.size() == 0) begin
          $display("%0t: unexpected result word, expected none, actual %0h", $time, m_axis_tdata);
          errors++;
        end else begin
          want = status_due.pop_front();
          check_field("tx_line", want.tx_line, got.tx_line);
          check_field("read_byte", want.read_byte, got.read_byte);
          check_field("read_valid", want.read_valid, got.read_valid);
          check_field("tx_full", want.tx_full, got.tx_full);
          check_field("rx_available", want.rx_avail, got.rx_avail);
          check_field("dropped_frames", want.drops, got.drops);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("Timeout: no word moved for %0d cycles", StallLimit);
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_word(logic [1:0] op, logic [7:0] data, logic level);
    word_t w;
    w.op = op;
    w.data = data;
    w.level = level;
    pending_words.push_back(w);
    words_queued++;
    if (op != OpUnused) stim_count++;
  endtask

  task automatic queue_tick(logic level);
    if ($urandom_range(0, 99) < push_pct) queue_word(OP_PUSH, 8'($urandom), 1'($urandom));
    if ($urandom_range(0, 99) < pop_pct) queue_word(OP_POP, 8'($urandom), 1'($urandom));
    if ($urandom_range(0, 99) < odd_pct) queue_word(OpUnused, 8'($urandom), 1'($urandom));
    queue_word(OP_TICK, 8'($urandom), level);
  endtask

  task automatic queue_frame(logic [7:0] value, int unsigned ticks, logic stop_level);
    int unsigned len;
    len = (ticks < 2) ? 1 : ticks;
    repeat ($urandom_range(1, 3)) queue_tick(1'b1);
    repeat (len + ((ticks < 2) ? 1 : 0)) queue_tick(1'b0);
    for (int i = 0; i < DataBits; i++) begin
      repeat (len) queue_tick(value[i]);
    end
    repeat (len) queue_tick(stop_level);
    if (!stop_level) queue_tick(1'b1);
  endtask

  task automatic drain();
    while (words_in != words_queued || status_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_bit_ticks(logic [15:0] value);
    drain();
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    bit_ticks = value;
    settings_used++;
  endtask

  task automatic mixed_run(int unsigned ticks, int unsigned frames);
    int unsigned pick;
    set_bit_ticks(16'(ticks));
    gap_pct = $urandom_range(0, 3) * 10;
    stall_pct = $urandom_range(0, 3) * 10;
    push_pct = $urandom_range(5, 20);
    pop_pct = $urandom_range(5, 20);
    odd_pct = 2;
    repeat (frames) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        queue_frame(8'($urandom), ticks, 1'b1);
      end else if (pick == 7) begin
        queue_frame(8'($urandom), ticks, 1'b0);
      end else if (pick == 8) begin
        queue_tick(1'b0);
        repeat ($urandom_range(0, ticks / 2)) queue_tick(1'b0);
        repeat ($urandom_range(1, ticks + 1)) queue_tick(1'b1);
      end else begin
        repeat ($urandom_range(3, 10)) queue_tick(1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin : run_regression
    int unsigned periods[7];
    periods = '{2, 3, 4, 1, 0, 5, 2};
    bit_ticks = TpbReset;
    tx_rd = 0; tx_wr = 0; rx_rd = 0; rx_wr = 0;
    tx_full_m = 1'b0; rx_full_m = 1'b0;
    tx_sh = '1; tx_left = 0; tx_cnt = '0;
    rx_ph = RX_IDLE; rx_sh = '0; rx_idx = 0; rx_cnt = '0; rx_last = 1'b1;
    drops_m = '0; frames_kept = 0; bytes_sent = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    queue_word(OP_POP, 8'hFF, 1'b1);
    queue_word(OpUnused, 8'h00, 1'b0);
    queue_word(OP_PUSH, 8'h00, 1'b0);
    queue_word(OP_PUSH, 8'hFF, 1'b1);
    queue_word(OP_PUSH, 8'hA5, 1'b0);
    queue_word(OP_TICK, 8'h5A, 1'b1);
    queue_word(OP_TICK, 8'hFF, 1'b0);
    queue_word(OP_TICK, 8'h00, 1'b1);
    set_bit_ticks(16'hFFFF);
    queue_word(OP_TICK, 8'h00, 1'b0);
    queue_word(OP_TICK, 8'hFF, 1'b0);
    set_bit_ticks(16'd1);
    queue_word(OP_TICK, 8'h00, 1'b1);
    queue_word(OP_TICK, 8'h00, 1'b0);
    queue_word(OP_TICK, 8'h00, 1'b1);
    queue_frame(8'h5A, 1, 1'b1);
    queue_word(OP_POP, 8'h00, 1'b0);
    set_bit_ticks(16'd0);
    queue_frame(8'hC3, 0, 1'b1);
    queue_word(OP_POP, 8'h00, 1'b0);

    set_bit_ticks(16'd1);
    push_pct = 0; pop_pct = 0; odd_pct = 0; gap_pct = 0; stall_pct = 0;
    hold_asks++;
    repeat (20) queue_word(OP_PUSH, 8'($urandom), 1'($urandom));
    repeat (19) queue_frame(8'($urandom), 1, 1'b1);
    drain();
    gap_pct = 20; stall_pct = 20;
    repeat (18) queue_word(OP_POP, 8'($urandom), 1'($urandom));
    queue_tick(1'b1);

    while (stim_count < 790) mixed_run(periods[$urandom_range(0, 6)], $urandom_range(2, 5));

    set_bit_ticks(16'd2);
    gap_pct = 0; stall_pct = 0; push_pct = 10; pop_pct = 10; odd_pct = 2;
    repeat (4) queue_frame(8'($urandom), 2, 1'b1);
    drain();
    repeat (8) @(posedge clk_i);

    $display("Covered %0d words in, %0d result words, %0d bit-period settings",
             words_in, words_out, settings_used);
    $display("Frames stored %0d, frames lost to a full FIFO %0d, bytes sent %0d",
             frames_kept, drops_m, bytes_sent);
    if (errors == 0 && words_out == words_in) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/uart_pkg.sv
rtl/core/uart_fifo.sv
rtl/core/uart_tx.sv
rtl/core/uart_rx.sv
rtl/core/uart_8n1_with_fifos.sv
dv/uart_8n1_with_fifos_test.sv
